// ===== rtl/core/per_peer_admission_budget_macros.svh =====
// Assertion macros used by the admission budget checker.
`ifndef PER_PEER_ADMISSION_BUDGET_MACROS_SVH
`define PER_PEER_ADMISSION_BUDGET_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while reset is held.
`define PPAB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("admission budget check failed");

// Next-cycle implication, sampled on aclk, off while reset is held.
`define PPAB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("admission budget check failed");

`endif

// ===== rtl/core/ppab_pkg.sv =====
// Shared types and constants of the per-peer admission budget block.
`default_nettype none

package ppab_pkg;

    localparam int unsigned PEER_ID_W  = 6;
    localparam int unsigned PEER_SPAN  = 64;
    localparam int unsigned ACTION_W   = 3;
    localparam int unsigned BYTES_W    = 32;
    localparam int unsigned JOBS_W     = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned S_TDATA_W  = 40;
    localparam int unsigned M_TDATA_W  = 8;

    localparam logic [ACTION_W-1:0] ACT_RESERVE      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_RESERVE_WAIT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_START        = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RELEASE      = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_STOP         = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_TOTAL_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_PEER_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_TOTAL_JOBS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_PEER_JOBS   = 2'd3;

    typedef struct packed {
        logic              waiting;
        logic [JOBS_W-1:0] jobs;
        logic [BYTES_W-1:0] bytes;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic accept;
        logic commit;
        logic clear_step;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_blocked;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/ppab_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ppab_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                    aclk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ppab_ctrl.sv =====
// Sequencer: table clearing after reset, request accept and commit.
`default_nettype none

module ppab_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire ppab_pkg::sts_t sts,
    output ppab_pkg::cmd_t     cmd
);

    ppab_pkg::state_t state_reg;
    ppab_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ppab_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ppab_pkg::ST_CLEAR: begin
                if (sts.clear_last) begin
                    state_next = ppab_pkg::ST_IDLE;
                end
            end
            ppab_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ppab_pkg::ST_EXEC;
                end
            end
            ppab_pkg::ST_EXEC: begin
                if (!sts.out_blocked) begin
                    state_next = ppab_pkg::ST_IDLE;
                end
            end
            default: state_next = ppab_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ppab_pkg::ST_CLEAR: begin
                cmd.clear_step = 1'b1;
            end
            ppab_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ppab_pkg::ST_EXEC: begin
                cmd.commit = !sts.out_blocked;
            end
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/ppab_dp.sv =====
// Datapath: limits, global counters, peer table and budget checks.
`default_nettype none

module ppab_dp #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire ppab_pkg::cmd_t                        cmd,
    output ppab_pkg::sts_t                             sts,
    input  wire logic [ppab_pkg::ACTION_W-1:0]         in_action,
    input  wire logic [ppab_pkg::PEER_ID_W-1:0]        in_peer_id,
    input  wire logic [ppab_pkg::BYTES_W-1:0]          in_amount,
    input  wire logic                                  in_was_started,
    input  wire logic                                  cfg_we,
    input  wire logic [ppab_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [ppab_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       out_granted,
    output logic                                       out_started
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned BW = ppab_pkg::BYTES_W;
    localparam int unsigned JW = ppab_pkg::JOBS_W;

    // Peer index folded into the table depth.
    logic [AW-1:0] peer_map [ppab_pkg::PEER_SPAN];
    for (genvar g = 0; g < ppab_pkg::PEER_SPAN; g++) begin : g_map
        assign peer_map[g] = AW'(g % DEPTH);
    end

    logic [BW-1:0] lim_tbytes_reg, lim_pbytes_reg;
    logic [JW-1:0] lim_tjobs_reg, lim_pjobs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_tbytes_reg <= '0;
            lim_pbytes_reg <= '0;
            lim_tjobs_reg  <= '0;
            lim_pjobs_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ppab_pkg::REG_LIMIT_TOTAL_BYTES: lim_tbytes_reg <= cfg_data;
                ppab_pkg::REG_LIMIT_PEER_BYTES:  lim_pbytes_reg <= cfg_data;
                ppab_pkg::REG_LIMIT_TOTAL_JOBS:  lim_tjobs_reg  <= cfg_data[JW-1:0];
                ppab_pkg::REG_LIMIT_PEER_JOBS:   lim_pjobs_reg  <= cfg_data[JW-1:0];
                default: lim_tbytes_reg <= lim_tbytes_reg;
            endcase
        end
    end

    // Captured request
    logic [ppab_pkg::ACTION_W-1:0] act_reg;
    logic [AW-1:0]                 addr_reg;
    logic [BW-1:0]                 amt_reg;
    logic                          was_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            act_reg  <= in_action;
            addr_reg <= peer_map[in_peer_id];
            amt_reg  <= in_amount;
            was_reg  <= in_was_started;
        end
    end

    // Clearing sweep
    logic [AW-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // Peer table
    ppab_pkg::entry_t ent_rd, ent_wr;
    logic [ppab_pkg::ENTRY_W-1:0] ram_rdata;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [ppab_pkg::ENTRY_W-1:0] ram_wdata;

    assign ram_we    = cmd.clear_step | cmd.commit;
    assign ram_waddr = cmd.clear_step ? clr_cnt_reg : addr_reg;
    assign ram_wdata = cmd.clear_step ? '0 : ent_wr;
    assign ent_rd    = ram_rdata;

    ppab_ram #(
        .WIDTH (ppab_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.accept),
        .raddr (peer_map[in_peer_id]),
        .rdata (ram_rdata)
    );

    // Global state
    logic          stopped_reg, stopped_next;
    logic [BW-1:0] tbytes_reg, tbytes_next;
    logic [JW-1:0] trun_reg, trun_next;
    logic [JW-1:0] twait_reg, twait_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stopped_reg <= 1'b0;
            tbytes_reg  <= '0;
            trun_reg    <= '0;
            twait_reg   <= '0;
        end else if (cmd.commit) begin
            stopped_reg <= stopped_next;
            tbytes_reg  <= tbytes_next;
            trun_reg    <= trun_next;
            twait_reg   <= twait_next;
        end
    end

    // Budget checks
    logic [BW:0] tsum, psum;
    logic        fits_total, fits_peer, base_ok, can_run, can_wait;
    logic        granted, started;

    assign tsum       = {1'b0, tbytes_reg} + {1'b0, amt_reg};
    assign psum       = {1'b0, ent_rd.bytes} + {1'b0, amt_reg};
    assign fits_total = (amt_reg == '0) || (tsum <= {1'b0, lim_tbytes_reg});
    assign fits_peer  = (amt_reg == '0) || (psum <= {1'b0, lim_pbytes_reg});
    assign base_ok    = !stopped_reg && (amt_reg <= lim_tbytes_reg)
                        && (amt_reg <= lim_pbytes_reg) && (lim_pjobs_reg != '0)
                        && fits_total && fits_peer;
    assign can_run    = (trun_reg < lim_tjobs_reg) && (ent_rd.jobs < lim_pjobs_reg)
                        && !ent_rd.waiting;
    assign can_wait   = (twait_reg < lim_tjobs_reg) && !ent_rd.waiting;

    always_comb begin
        stopped_next = stopped_reg;
        tbytes_next  = tbytes_reg;
        trun_next    = trun_reg;
        twait_next   = twait_reg;
        ent_wr       = ent_rd;
        granted      = 1'b0;
        started      = 1'b0;
        unique case (act_reg)
            ppab_pkg::ACT_RESERVE, ppab_pkg::ACT_RESERVE_WAIT: begin
                if (base_ok && (can_run
                        || ((act_reg == ppab_pkg::ACT_RESERVE_WAIT) && can_wait))) begin
                    granted      = 1'b1;
                    started      = can_run;
                    tbytes_next  = tsum[BW-1:0];
                    ent_wr.bytes = psum[BW-1:0];
                    if (can_run) begin
                        trun_next   = trun_reg + JW'(1);
                        ent_wr.jobs = ent_rd.jobs + JW'(1);
                    end else begin
                        twait_next     = twait_reg + JW'(1);
                        ent_wr.waiting = 1'b1;
                    end
                end
            end
            ppab_pkg::ACT_START: begin
                if (!stopped_reg) begin
                    if (was_reg) begin
                        granted = 1'b1;
                        started = 1'b1;
                    end else if ((trun_reg < lim_tjobs_reg)
                            && (ent_rd.jobs < lim_pjobs_reg)) begin
                        granted        = 1'b1;
                        started        = 1'b1;
                        twait_next     = (twait_reg != '0) ? twait_reg - JW'(1) : '0;
                        ent_wr.waiting = 1'b0;
                        trun_next      = trun_reg + JW'(1);
                        ent_wr.jobs    = ent_rd.jobs + JW'(1);
                    end
                end
            end
            ppab_pkg::ACT_RELEASE: begin
                granted      = 1'b1;
                tbytes_next  = (tbytes_reg > amt_reg) ? tbytes_reg - amt_reg : '0;
                ent_wr.bytes = (ent_rd.bytes > amt_reg) ? ent_rd.bytes - amt_reg : '0;
                if (was_reg) begin
                    trun_next   = (trun_reg != '0) ? trun_reg - JW'(1) : '0;
                    ent_wr.jobs = (ent_rd.jobs != '0) ? ent_rd.jobs - JW'(1) : '0;
                end else begin
                    twait_next     = (twait_reg != '0) ? twait_reg - JW'(1) : '0;
                    ent_wr.waiting = 1'b0;
                end
            end
            ppab_pkg::ACT_STOP: begin
                granted      = 1'b1;
                stopped_next = 1'b1;
            end
            default: granted = 1'b0;
        endcase
    end

    // Output register
    logic out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_granted <= granted;
            out_started <= started;
        end
    end

    assign out_valid       = out_valid_reg;
    assign sts.out_blocked = out_valid_reg && !out_ready;
    assign sts.clear_last  = (clr_cnt_reg == AW'(DEPTH - 1));

endmodule

`default_nettype wire

// ===== rtl/core/per_peer_admission_budget.sv =====
// Top level of the per-peer admission budget controller.
// Each request beat is checked against total and per-peer byte and job budgets
// and answered by exactly one result beat (granted, started). The accept
// cycle reads the peer's entry from the peer table RAM (registered read), the
// execute state then checks the budgets and writes the entry back on commit,
// and a new request is taken only after that commit. The result sits in
// an output register; while it waits to be taken the next request is still
// accepted, and only its commit holds until the output register frees. After
// reset the peer table is swept to zero, one entry per cycle, over all
// min(PEER_COUNT, 64) entries; s_tready stays low during the sweep while
// configuration writes are taken as usual. The peer index is peer_id modulo
// PEER_COUNT. Write the limit registers only while no request is in flight.
`default_nettype none

module per_peer_admission_budget #(
    parameter int unsigned PEER_COUNT = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Request channel
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // tdata: peer_id[5:0], amount[37:6], was_started[38], zero[39]
    input  wire logic [ppab_pkg::S_TDATA_W-1:0]    s_tdata,
    // tuser: action[2:0]
    input  wire logic [ppab_pkg::ACTION_W-1:0]     s_tuser,
    // Result channel
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // tdata: granted[0], started[1], zero[7:2]
    output logic      [ppab_pkg::M_TDATA_W-1:0]    m_tdata,
    // Configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ppab_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ppab_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Only peer indices below 64 can be addressed, so the table stops there.
    localparam int unsigned TABLE_DEPTH =
        (PEER_COUNT < ppab_pkg::PEER_SPAN) ? PEER_COUNT : ppab_pkg::PEER_SPAN;

    ppab_pkg::cmd_t cmd;
    ppab_pkg::sts_t sts;
    logic           granted, started;

    // Limit registers are always writable.
    assign cfg_ready = 1'b1;

    ppab_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ppab_dp #(
        .DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .in_action      (s_tuser),
        .in_peer_id     (s_tdata[5:0]),
        .in_amount      (s_tdata[37:6]),
        .in_was_started (s_tdata[38]),
        .cfg_we         (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_granted    (granted),
        .out_started    (started)
    );

    // Pack the result beat; upper bits pad to a whole byte.
    assign m_tdata = {6'b0, started, granted};

endmodule

`default_nettype wire

// ===== rtl/core/ppab_checker.sv =====
// Port-level checker for the admission budget block, bound to the top level.
`default_nettype none
`include "per_peer_admission_budget_macros.svh"

module ppab_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [ppab_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result beat holds its value.
    `PPAB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // A request occupies the block for its check cycle.
    `PPAB_ASSERT_NEXT(a_seq_accept, s_tvalid && s_tready, !s_tready)

    // Nothing is started without being granted.
    `PPAB_ASSERT_NOW(a_started_granted, m_tvalid, !(m_tdata[1] && !m_tdata[0]))

    // The table sweep runs first after reset, so no request is taken.
    `PPAB_ASSERT_NOW(a_clear_first, $past(!aresetn), !s_tready)

endmodule

bind per_peer_admission_budget ppab_checker u_ppab_checker (.*);

`default_nettype wire
